// ===== design/tksum_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tksum_pkg
// shared widths, defaults and control types of the top-k sum unit
// ----------------------------------------------------------------------------
package tksum_pkg;

    localparam int VAL_W     = 30;    // sample width
    localparam int CFG_W     = 11;    // keep_count register width
    localparam int OUT_W     = 40;    // top_sum width
    localparam int K_MAX_DEF = 1024;  // default store depth

    localparam logic [CFG_W-1:0] KEEP_RESET = CFG_W'(1024);
    localparam logic [OUT_W-1:0] SUM_MAX    = '1;

    // command from the sequencer to the scan unit
    typedef struct packed {
        logic start;    // begin one pass over the store
        logic replace;  // swap the first copy of the minimum for the new value
    } t_scan_ctl;

endpackage
`default_nettype wire

// ===== design/tksum_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tksum_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tksum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/tksum_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tksum_scan
// one pass over the store: replace, minimum and sum, one entry per cycle
// ----------------------------------------------------------------------------
module tksum_scan #(
    parameter int K_MAX  = tksum_pkg::K_MAX_DEF,
    parameter int CNT_W  = $clog2(K_MAX + 1),
    parameter int ADDR_W = (K_MAX > 1) ? $clog2(K_MAX) : 1,
    parameter int SUM_W  = tksum_pkg::VAL_W + $clog2(K_MAX)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tksum_pkg::t_scan_ctl             i_ctl,
    input  wire logic [CNT_W-1:0]                 i_k,
    input  wire logic [tksum_pkg::VAL_W-1:0]      i_min,
    input  wire logic [tksum_pkg::VAL_W-1:0]      i_value,
    output logic                                  o_rd_en,
    output logic      [ADDR_W-1:0]                o_rd_addr,
    input  wire logic [tksum_pkg::VAL_W-1:0]      i_rd_data,
    output logic                                  o_wr_en,
    output logic      [ADDR_W-1:0]                o_wr_addr,
    output logic                                  o_done,
    output logic      [tksum_pkg::VAL_W-1:0]      o_acc_min,
    output logic      [SUM_W-1:0]                 o_acc_sum
);
    import tksum_pkg::*;

    logic              r_active;
    logic              r_replace;
    logic              r_found;
    logic [CNT_W-1:0]  r_addr;
    logic              r_vld;
    logic [CNT_W-1:0]  r_vaddr;
    logic              r_done;
    logic [VAL_W-1:0]  r_acc_min;
    logic [SUM_W-1:0]  r_acc_sum;

    logic              w_issue;
    logic              w_hit;
    logic              w_end;
    logic [VAL_W-1:0]  w_val;

    assign w_issue = r_active && (r_addr < i_k);

    // first stored copy of the old minimum takes the new value
    assign w_hit = r_vld && r_replace && !r_found && (i_rd_data == i_min);
    assign w_val = w_hit ? i_value : i_rd_data;
    assign w_end = r_vld && ((r_vaddr + CNT_W'(1)) == i_k);

    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_addr[ADDR_W-1:0];
    assign o_wr_en   = w_hit;
    assign o_wr_addr = r_vaddr[ADDR_W-1:0];
    assign o_done    = r_done;
    assign o_acc_min = r_acc_min;
    assign o_acc_sum = r_acc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_vld    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_vld  <= w_issue;
            r_done <= w_end;
            if (i_ctl.start) begin
                r_active <= 1'b1;
            end else if (w_end) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vaddr <= r_addr;
        if (i_ctl.start) begin
            r_addr    <= '0;
            r_found   <= 1'b0;
            r_replace <= i_ctl.replace;
            r_acc_min <= '1;
            r_acc_sum <= '0;
        end else begin
            if (w_issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (r_vld) begin
                if (w_hit) begin
                    r_found <= 1'b1;
                end
                if (w_val < r_acc_min) begin
                    r_acc_min <= w_val;
                end
                r_acc_sum <= r_acc_sum + SUM_W'(w_val);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/streaming_top_k_sum_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// streaming_top_k_sum_unit
// streaming sum of the k largest values of a run
// ----------------------------------------------------------------------------
// usage
//   input: drive i_sample_value and i_is_last with start high; the transfer
//   takes place at a clock edge where start is high and busy is low.
//   config: i_cfg_keep_count is written when i_cfg_valid and o_cfg_ready are
//   both high; write only while the unit is idle. k = 0 acts as 1 and values
//   above K_MAX act as K_MAX.
//   result: one transfer per run, on the item marked last; o_strobe is high
//   for exactly one cycle with o_top_sum and o_too_few. the receiver cannot
//   stall the unit, so it must take the result in that cycle.
// timing
//   an item that only fills the store or is dropped leaves busy low, and a
//   result, if any, follows in the next cycle.
//   an item that replaces a stored value, completes the fill of a run that
//   goes on, or ends a run whose store holds more than k entries starts a
//   scan of the k stored entries through the single ram read port; busy
//   is high for the scan; the result strobe comes in the cycle busy drops.
// reset
//   synchronous, active low; clears the run state and sets keep_count to
//   1024. ram contents are not cleared, only entries written in the current
//   run are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module streaming_top_k_sum_unit #(
    parameter int K_MAX = tksum_pkg::K_MAX_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tksum_pkg::VAL_W-1:0]  i_sample_value,
    input  wire logic                         i_is_last,
    // result channel
    output logic                              o_strobe,
    output logic      [tksum_pkg::OUT_W-1:0]  o_top_sum,
    output logic                              o_too_few,
    // config channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [tksum_pkg::CFG_W-1:0]  i_cfg_keep_count
);
    import tksum_pkg::*;

    localparam int CNT_W  = $clog2(K_MAX + 1);
    localparam int ADDR_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int SUM_W  = VAL_W + $clog2(K_MAX);
    localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // what to do with the scan results
    typedef struct packed {
        logic upd_min;
        logic upd_sum;
        logic emit;
    } t_pass;

    // clamp the sum to the result width
    function automatic logic [OUT_W-1:0] f_sat(input logic [SUM_W-1:0] s);
        logic [EXT_W-1:0] x;
        x = EXT_W'(s);
        if (x > EXT_W'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return OUT_W'(x);
    endfunction

    // state
    t_state            r_state,   n_state;
    logic [CFG_W-1:0]  r_keep;
    logic [CNT_W-1:0]  r_seen,    n_seen;
    logic [VAL_W-1:0]  r_min,     n_min;
    logic [SUM_W-1:0]  r_sum,     n_sum;
    logic [VAL_W-1:0]  r_value,   n_value;
    logic              r_last,    n_last;
    t_pass             r_pass,    n_pass;
    logic              r_strobe,  n_strobe;
    logic [OUT_W-1:0]  r_top_sum, n_top_sum;
    logic              r_too_few, n_too_few;

    // datapath wires
    logic [31:0]       w_keep_ext;
    logic [CNT_W-1:0]  w_k;
    logic              w_accept;
    logic              w_fill;
    logic [CNT_W-1:0]  w_seen_inc;
    logic [SUM_W-1:0]  w_fill_sum;
    t_scan_ctl         w_ctl;

    // ram and scan wires
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [VAL_W-1:0]  w_rd_data;
    logic              w_scan_we;
    logic [ADDR_W-1:0] w_scan_waddr;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [VAL_W-1:0]  w_ram_wdata;
    logic              w_scan_done;
    logic [VAL_W-1:0]  w_acc_min;
    logic [SUM_W-1:0]  w_acc_sum;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_top_sum   = r_top_sum;
    assign o_too_few   = r_too_few;

    // effective k: zero acts as one, clamp at the store depth
    assign w_keep_ext = 32'(r_keep);
    assign w_k = (r_keep == '0)              ? CNT_W'(1) :
                 (w_keep_ext > 32'(K_MAX))   ? CNT_W'(K_MAX) :
                                               CNT_W'(w_keep_ext);

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_fill     = (r_seen < w_k);
    assign w_seen_inc = r_seen + CNT_W'(1);
    assign w_fill_sum = r_sum + SUM_W'(i_sample_value);

    // fill writes at the accept edge, replace writes during a scan
    assign w_ram_we    = (w_accept && w_fill) || w_scan_we;
    assign w_ram_waddr = w_scan_we ? w_scan_waddr : r_seen[ADDR_W-1:0];
    assign w_ram_wdata = w_scan_we ? r_value : i_sample_value;

    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_min     = r_min;
        n_sum     = r_sum;
        n_value   = r_value;
        n_last    = r_last;
        n_pass    = r_pass;
        n_strobe  = 1'b0;
        n_top_sum = r_top_sum;
        n_too_few = r_too_few;
        w_ctl     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value = i_sample_value;
                    n_last  = i_is_last;
                    if (w_fill) begin
                        // fill phase: store in order, running sum
                        n_seen = w_seen_inc;
                        n_sum  = w_fill_sum;
                        if (i_is_last) begin
                            n_strobe  = 1'b1;
                            n_too_few = (w_seen_inc < w_k);
                            n_top_sum = (w_seen_inc < w_k) ? '0 : f_sat(w_fill_sum);
                            n_seen    = '0;
                            n_min     = '0;
                            n_sum     = '0;
                        end else if (w_seen_inc == w_k) begin
                            // store just filled: find its minimum
                            w_ctl.start = 1'b1;
                            n_pass      = '{upd_min: 1'b1, upd_sum: 1'b0, emit: 1'b0};
                            n_state     = S_SCAN;
                        end
                    end else if (i_sample_value > r_min) begin
                        w_ctl.start   = 1'b1;
                        w_ctl.replace = 1'b1;
                        n_pass  = '{upd_min: 1'b1, upd_sum: 1'b1, emit: i_is_last};
                        n_state = S_SCAN;
                    end else if (i_is_last) begin
                        if (r_seen == w_k) begin
                            n_strobe  = 1'b1;
                            n_too_few = 1'b0;
                            n_top_sum = f_sat(r_sum);
                            n_seen    = '0;
                            n_min     = '0;
                            n_sum     = '0;
                        end else begin
                            // store holds more than k entries: sum the first k
                            w_ctl.start = 1'b1;
                            n_pass  = '{upd_min: 1'b0, upd_sum: 1'b0, emit: 1'b1};
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    if (r_pass.upd_min) begin
                        n_min = w_acc_min;
                    end
                    if (r_pass.upd_sum) begin
                        n_sum = w_acc_sum;
                    end
                    if (r_pass.emit) begin
                        n_strobe  = 1'b1;
                        n_too_few = 1'b0;
                        n_top_sum = f_sat(w_acc_sum);
                    end
                    if (r_last) begin
                        n_seen = '0;
                        n_min  = '0;
                        n_sum  = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_keep   <= KEEP_RESET;
            r_seen   <= '0;
            r_min    <= '0;
            r_sum    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_min    <= n_min;
            r_sum    <= n_sum;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_keep <= i_cfg_keep_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_last    <= n_last;
        r_pass    <= n_pass;
        r_top_sum <= n_top_sum;
        r_too_few <= n_too_few;
    end

    // store of kept values
    tksum_ram #(
        .WIDTH (VAL_W),
        .DEPTH (K_MAX),
        .AW    (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // scan unit: read, replace in place, accumulate minimum and sum
    tksum_scan #(
        .K_MAX  (K_MAX),
        .CNT_W  (CNT_W),
        .ADDR_W (ADDR_W),
        .SUM_W  (SUM_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_k       (w_k),
        .i_min     (r_min),
        .i_value   (r_value),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_scan_we),
        .o_wr_addr (w_scan_waddr),
        .o_done    (w_scan_done),
        .o_acc_min (w_acc_min),
        .o_acc_sum (w_acc_sum)
    );

`ifndef NO_ASSERTIONS
    // fill count never runs past the store
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_seen) <= 32'(K_MAX))
        else $error("fill count beyond store depth");

    // a scan only finishes while the sequencer waits for it
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_done |-> (r_state == S_SCAN))
        else $error("scan done outside a scan");

    // an item that does not end a run never yields an immediate result
    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_is_last) |=> !o_strobe)
        else $error("result without a last item");

    // the error result carries a zero sum
    a_too_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_too_few) |-> (o_top_sum == '0))
        else $error("too_few result with nonzero sum");
`endif

endmodule
`default_nettype wire
